// ===== rtl/core/ict_pkg.sv =====
package ict_pkg;

	// default sizes
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int ANGLE_WIDTH_DEF  = 24;
	localparam int CORDIC_STEPS_DEF = 16;

	// fixed field and register widths
	localparam int MS_W    = 16;
	localparam int ALPHA_W = 17;
	localparam int GAIN_W  = 24;
	localparam int CFG_W   = 24;

	// cordic angle accumulator, 1/65536 degree
	localparam int ZACC_W = 25;

	// gyro step is rounded from q24
	localparam int GYRO_SHIFT = 24;
	localparam int GYRO_HALF  = 8388608;

	// blend constants
	localparam int ALPHA_ONE  = 65536;
	localparam int BLEND_HALF = 32768;

	// register reset values
	localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd64225;
	localparam logic [GAIN_W-1:0]  GAIN_RST  = 24'd65572;

	// register indexes
	typedef enum logic [0:0] {
		CFG_ALPHA = 1'b0,
		CFG_GAIN  = 1'b1
	} cfg_idx_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [ZACC_W-1:0] atan_step(input int idx);
		logic signed [ZACC_W-1:0] a;
		case (idx)
			0: a = 25'sd2949120;
			1: a = 25'sd1740967;
			2: a = 25'sd919879;
			3: a = 25'sd466945;
			4: a = 25'sd234379;
			5: a = 25'sd117304;
			6: a = 25'sd58666;
			7: a = 25'sd29335;
			8: a = 25'sd14668;
			9: a = 25'sd7334;
			10: a = 25'sd3667;
			11: a = 25'sd1833;
			12: a = 25'sd917;
			13: a = 25'sd458;
			14: a = 25'sd229;
			15: a = 25'sd115;
			16: a = 25'sd57;
			17: a = 25'sd29;
			18: a = 25'sd14;
			19: a = 25'sd7;
			20: a = 25'sd4;
			21: a = 25'sd2;
			22: a = 25'sd1;
			default: a = 25'sd0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/core/ict_sqrt_cell.sv =====
module ict_sqrt_cell #(
	parameter int NW   = 48,
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_i,
	input  logic [NW-1:0] nx_i,
	input  logic [NW-1:0] rx_i,
	input  logic [NW-1:0] ny_i,
	input  logic [NW-1:0] ry_i,
	output logic          valid_o,
	output logic [NW-1:0] nx_o,
	output logic [NW-1:0] rx_o,
	output logic [NW-1:0] ny_o,
	output logic [NW-1:0] ry_o
);

	localparam logic [NW-1:0] BIT = {{(NW-1){1'b0}}, 1'b1} << (2 * STEP);

	logic [NW-1:0] tx, ty;
	logic [NW-1:0] nx_d, rx_d, ny_d, ry_d;

	// one restoring root step per axis
	always_comb begin
		tx = rx_i + BIT;
		ty = ry_i + BIT;
		if (nx_i >= tx) begin
			nx_d = nx_i - tx;
			rx_d = (rx_i >> 1) + BIT;
		end else begin
			nx_d = nx_i;
			rx_d = rx_i >> 1;
		end
		if (ny_i >= ty) begin
			ny_d = ny_i - ty;
			ry_d = (ry_i >> 1) + BIT;
		end else begin
			ny_d = ny_i;
			ry_d = ry_i >> 1;
		end
	end

	// token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		nx_o <= nx_d;
		rx_o <= rx_d;
		ny_o <= ny_d;
		ry_o <= ry_d;
	end

endmodule

// ===== rtl/core/ict_cordic_cell.sv =====
module ict_cordic_cell #(
	parameter int CW   = 27,
	parameter int STEP = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid_i,
	input  logic signed [CW-1:0]             x_i,
	input  logic signed [CW-1:0]             y_i,
	input  logic signed [ict_pkg::ZACC_W-1:0] z_i,
	output logic                             valid_o,
	output logic signed [CW-1:0]             x_o,
	output logic signed [CW-1:0]             y_o,
	output logic signed [ict_pkg::ZACC_W-1:0] z_o
);

	localparam logic signed [ict_pkg::ZACC_W-1:0] ANG = ict_pkg::atan_step(STEP);

	logic signed [CW-1:0] dx, dy;
	logic                 pos;

	// vectoring rotation towards y = 0
	always_comb begin
		dx  = y_i >>> STEP;
		dy  = x_i >>> STEP;
		pos = !y_i[CW-1] && (|y_i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (pos) begin
			x_o <= x_i + dx;
			y_o <= y_i - dy;
			z_o <= z_i + ANG;
		end else begin
			x_o <= x_i - dx;
			y_o <= y_i + dy;
			z_o <= z_i - ANG;
		end
	end

endmodule

// ===== rtl/core/imu_complementary_tilt_filter.sv =====
// channel  | dir | handshake         | payload
// s_       | in  | s_tvalid/s_tready | accel x,y,z, rate x,y,z, elapsed_ms
// m_       | out | m_tvalid/m_tready | tilt_x, tilt_y, heading_z
// cfg_     | in  | cfg_we            | cfg_index, cfg_data
//
// one sample at a time, from the captured input through stage 1, the root cell chain,
// the cordic cell chain, the accelerometer angle and the blend products to the output
// the next sample is taken as soon as the result lands in the output register,
// even while that result still waits for m_tready
// a stalled output holds the final blend stage, the cell chains are empty then
// reset restores the register defaults and clears the kept angles
module imu_complementary_tilt_filter #(
	parameter int SAMPLE_WIDTH = ict_pkg::SAMPLE_WIDTH_DEF,
	parameter int ANGLE_WIDTH  = ict_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STEPS = ict_pkg::CORDIC_STEPS_DEF,
	localparam int IN_W   = 6 * SAMPLE_WIDTH + ict_pkg::MS_W,
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W  = 3 * ANGLE_WIDTH,
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, elapsed_ms
	input  logic [IN_TW-1:0]          s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// tilt_x, tilt_y, heading_z
	output logic [OUT_TW-1:0]         m_tdata,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [ict_pkg::CFG_W-1:0] cfg_data
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int AW  = ANGLE_WIDTH;
	localparam int RW  = SW + 8;
	localparam int NW  = 2 * RW;
	localparam int CW  = RW + 3;
	localparam int ZW  = ict_pkg::ZACC_W;
	localparam int AAW = ZW - 8;
	localparam int MW  = SW + ict_pkg::GAIN_W;
	localparam int PW  = MW + ict_pkg::MS_W;
	localparam int STW = PW + 2 - ict_pkg::GYRO_SHIFT;
	localparam int GW  = (AW > STW ? AW : STW) + 1;
	localparam int BW  = GW + 19;
	localparam int SHW = BW - 16;

	// configuration registers
	logic [ict_pkg::ALPHA_W-1:0] alpha_q;
	logic [ict_pkg::GAIN_W-1:0]  gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ict_pkg::ALPHA_RST;
			gain_q  <= ict_pkg::GAIN_RST;
		end else if (cfg_we) begin
			case (ict_pkg::cfg_idx_t'(cfg_index))
				ict_pkg::CFG_ALPHA: alpha_q <= cfg_data[ict_pkg::ALPHA_W-1:0];
				ict_pkg::CFG_GAIN:  gain_q  <= cfg_data[ict_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// control tokens
	logic busy_q, in_valid_q, st1_valid_q, st2_valid_q, acc_valid_q, prod_valid_q;
	logic m_tvalid_q;
	logic accept, wr;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign wr       = prod_valid_q && (!m_tvalid_q || m_tready);

	// captured sample
	logic signed [SW-1:0]      ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic [ict_pkg::MS_W-1:0] ms_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			ax_q <= $signed(s_tdata[0*SW +: SW]);
			ay_q <= $signed(s_tdata[1*SW +: SW]);
			az_q <= $signed(s_tdata[2*SW +: SW]);
			gx_q <= $signed(s_tdata[3*SW +: SW]);
			gy_q <= $signed(s_tdata[4*SW +: SW]);
			gz_q <= $signed(s_tdata[5*SW +: SW]);
			ms_q <= s_tdata[6*SW +: ict_pkg::MS_W];
		end
	end

	// magnitudes
	logic [SW-1:0] max_c, may_c, maz_c, mgx_c, mgy_c, mgz_c;

	always_comb begin
		max_c = ax_q[SW-1] ? SW'(-ax_q) : SW'(ax_q);
		may_c = ay_q[SW-1] ? SW'(-ay_q) : SW'(ay_q);
		maz_c = az_q[SW-1] ? SW'(-az_q) : SW'(az_q);
		mgx_c = gx_q[SW-1] ? SW'(-gx_q) : SW'(gx_q);
		mgy_c = gy_q[SW-1] ? SW'(-gy_q) : SW'(gy_q);
		mgz_c = gz_q[SW-1] ? SW'(-gz_q) : SW'(gz_q);
	end

	// stage 1: squares and rate times gain
	logic [2*SW-1:0] sqx_s1, sqy_s1, sqz_s1;
	logic [MW-1:0]   m1x_s1, m1y_s1, m1z_s1;

	always_ff @(posedge clk) begin
		if (in_valid_q) begin
			sqx_s1 <= max_c * max_c;
			sqy_s1 <= may_c * may_c;
			sqz_s1 <= maz_c * maz_c;
			m1x_s1 <= mgx_c * gain_q;
			m1y_s1 <= mgy_c * gain_q;
			m1z_s1 <= mgz_c * gain_q;
		end
	end

	// stage 2: times elapsed time
	logic [PW-1:0] m2x_s2, m2y_s2, m2z_s2;

	always_ff @(posedge clk) begin
		if (st1_valid_q) begin
			m2x_s2 <= m1x_s1 * ms_q;
			m2y_s2 <= m1y_s1 * ms_q;
			m2z_s2 <= m1z_s1 * ms_q;
		end
	end

	// kept angles, also the output register
	logic signed [AW-1:0] prev_x_q, prev_y_q, prev_z_q;

	// stage 3: signed rounded gyro step onto the kept angle
	logic signed [PW+1:0] vx_c, vy_c, vz_c;
	logic signed [GW-1:0] gyr_x_q, gyr_y_q, gyr_z_q;
	localparam logic signed [PW+1:0] GHALF = (PW+2)'(ict_pkg::GYRO_HALF);

	always_comb begin
		vx_c = (gx_q[SW-1] ? -$signed({2'b00, m2x_s2}) : $signed({2'b00, m2x_s2})) + GHALF;
		vy_c = (gy_q[SW-1] ? -$signed({2'b00, m2y_s2}) : $signed({2'b00, m2y_s2})) + GHALF;
		vz_c = (gz_q[SW-1] ? -$signed({2'b00, m2z_s2}) : $signed({2'b00, m2z_s2})) + GHALF;
	end

	always_ff @(posedge clk) begin
		if (st2_valid_q) begin
			gyr_x_q <= GW'(prev_x_q) + GW'($signed(vx_c[PW+1:ict_pkg::GYRO_SHIFT]));
			gyr_y_q <= GW'(prev_y_q) + GW'($signed(vy_c[PW+1:ict_pkg::GYRO_SHIFT]));
			gyr_z_q <= GW'(prev_z_q) + GW'($signed(vz_c[PW+1:ict_pkg::GYRO_SHIFT]));
		end
	end

	// root cell chain, q8 root of the squared sums
	logic          sv [0:RW];
	logic [NW-1:0] snx [0:RW];
	logic [NW-1:0] srx [0:RW];
	logic [NW-1:0] sny [0:RW];
	logic [NW-1:0] sry [0:RW];

	assign sv[0]  = st1_valid_q;
	assign snx[0] = {(2*SW)'(sqy_s1 + sqz_s1), 16'd0};
	assign sny[0] = {(2*SW)'(sqx_s1 + sqz_s1), 16'd0};
	assign srx[0] = '0;
	assign sry[0] = '0;

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		ict_sqrt_cell #(
			.NW   (NW),
			.STEP (RW - 1 - k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (sv[k]),
			.nx_i    (snx[k]),
			.rx_i    (srx[k]),
			.ny_i    (sny[k]),
			.ry_i    (sry[k]),
			.valid_o (sv[k+1]),
			.nx_o    (snx[k+1]),
			.rx_o    (srx[k+1]),
			.ny_o    (sny[k+1]),
			.ry_o    (sry[k+1])
		);
	end

	// cordic cell chain, one cell per iteration and axis
	logic                 cv [0:CORDIC_STEPS];
	logic signed [CW-1:0] cxx [0:CORDIC_STEPS];
	logic signed [CW-1:0] cyx [0:CORDIC_STEPS];
	logic signed [ZW-1:0] czx [0:CORDIC_STEPS];
	logic                 cvy [0:CORDIC_STEPS];
	logic signed [CW-1:0] cxy [0:CORDIC_STEPS];
	logic signed [CW-1:0] cyy [0:CORDIC_STEPS];
	logic signed [ZW-1:0] czy [0:CORDIC_STEPS];

	assign cv[0]  = sv[RW];
	assign cvy[0] = sv[RW];
	assign cxx[0] = $signed({3'b000, srx[RW][RW-1:0]});
	assign cxy[0] = $signed({3'b000, sry[RW][RW-1:0]});
	assign cyx[0] = $signed({{3{ax_q[SW-1]}}, ax_q, 8'd0});
	assign cyy[0] = $signed({{3{ay_q[SW-1]}}, ay_q, 8'd0});
	assign czx[0] = '0;
	assign czy[0] = '0;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		ict_cordic_cell #(
			.CW   (CW),
			.STEP (k)
		) u_x (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (cv[k]),
			.x_i     (cxx[k]),
			.y_i     (cyx[k]),
			.z_i     (czx[k]),
			.valid_o (cv[k+1]),
			.x_o     (cxx[k+1]),
			.y_o     (cyx[k+1]),
			.z_o     (czx[k+1])
		);
		ict_cordic_cell #(
			.CW   (CW),
			.STEP (k)
		) u_y (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (cvy[k]),
			.x_i     (cxy[k]),
			.y_i     (cyy[k]),
			.z_i     (czy[k]),
			.valid_o (cvy[k+1]),
			.x_o     (cxy[k+1]),
			.y_o     (cyy[k+1]),
			.z_o     (czy[k+1])
		);
	end

	// accelerometer angle, rounded to 1/256 degree, zero for a zero numerator
	logic signed [ZW-1:0]  zrx_c, zry_c;
	logic signed [AAW-1:0] accx_q, accy_q;

	assign zrx_c = czx[CORDIC_STEPS] + ZW'(128);
	assign zry_c = czy[CORDIC_STEPS] + ZW'(128);

	always_ff @(posedge clk) begin
		if (cv[CORDIC_STEPS] && cvy[CORDIC_STEPS]) begin
			accx_q <= (ax_q == '0) ? '0 : $signed(zrx_c[ZW-1:8]);
			accy_q <= (ay_q == '0) ? '0 : $signed(zry_c[ZW-1:8]);
		end
	end

	// blend products
	logic [ict_pkg::ALPHA_W-1:0] alpha_c, beta_c;
	logic signed [GW+17:0]        p1x_q, p1y_q;
	logic signed [AAW+17:0]       p2x_q, p2y_q;

	always_comb begin
		alpha_c = (alpha_q > ict_pkg::ALPHA_W'(ict_pkg::ALPHA_ONE)) ?
			ict_pkg::ALPHA_W'(ict_pkg::ALPHA_ONE) : alpha_q;
		beta_c  = ict_pkg::ALPHA_W'(ict_pkg::ALPHA_ONE) - alpha_c;
	end

	always_ff @(posedge clk) begin
		if (acc_valid_q) begin
			p1x_q <= $signed({1'b0, alpha_c}) * gyr_x_q;
			p1y_q <= $signed({1'b0, alpha_c}) * gyr_y_q;
			p2x_q <= $signed({1'b0, beta_c}) * accx_q;
			p2y_q <= $signed({1'b0, beta_c}) * accy_q;
		end
	end

	// saturation to the angle range
	function automatic logic signed [AW-1:0] sat_sh(input logic signed [SHW-1:0] v);
		logic fits;
		fits = (&v[SHW-1:AW-1]) || !(|v[SHW-1:AW-1]);
		if (fits) return v[AW-1:0];
		return v[SHW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
	endfunction

	function automatic logic signed [AW-1:0] sat_g(input logic signed [GW-1:0] v);
		logic fits;
		fits = (&v[GW-1:AW-1]) || !(|v[GW-1:AW-1]);
		if (fits) return v[AW-1:0];
		return v[GW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
	endfunction

	logic signed [BW-1:0] bsx_c, bsy_c;

	assign bsx_c = BW'(p1x_q) + BW'(p2x_q) + BW'(ict_pkg::BLEND_HALF);
	assign bsy_c = BW'(p1y_q) + BW'(p2y_q) + BW'(ict_pkg::BLEND_HALF);

	// final blend into the kept tilt angles, gyro-only heading, and output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
		end else if (wr) begin
			prev_x_q <= sat_sh($signed(bsx_c[BW-1:16]));
			prev_y_q <= sat_sh($signed(bsy_c[BW-1:16]));
			prev_z_q <= sat_g(gyr_z_q);
		end
	end

	assign m_tdata = OUT_TW'({prev_z_q, prev_y_q, prev_x_q});

	// token sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			in_valid_q   <= 1'b0;
			st1_valid_q  <= 1'b0;
			st2_valid_q  <= 1'b0;
			acc_valid_q  <= 1'b0;
			prod_valid_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			in_valid_q  <= accept;
			st1_valid_q <= in_valid_q;
			st2_valid_q <= st1_valid_q;
			acc_valid_q <= cv[CORDIC_STEPS];
			if (acc_valid_q) begin
				prod_valid_q <= 1'b1;
			end else if (wr) begin
				prod_valid_q <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (wr) begin
				busy_q <= 1'b0;
			end
			if (wr) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// idle means no token in the captured input, accelerometer angle or blend product stage
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (!acc_valid_q && !prod_valid_q && !in_valid_q))
		else $error("token in flight while idle");

	// a transfer in closes the input until the result is written
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && !s_tready))
		else $error("input open after a transfer");

	// a write shows the result and frees the input
	a_write_out: assert property (@(posedge clk) disable iff (!arst_n)
		wr |=> (m_tvalid_q && !busy_q && !prod_valid_q))
		else $error("result write lost");

	// one sample at a time through the control stages
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({in_valid_q, st1_valid_q, st2_valid_q, acc_valid_q, prod_valid_q}))
		else $error("two samples in flight");

endmodule
